// ===== hw/rtl/stt_pkg.sv =====
// Shared types, constants and arithmetic helpers of the spherical tensor transform unit.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_ELEMS  = 9;
    localparam int COEF_BITS  = 30;

    localparam int TDATA_W = ((NUM_ELEMS * DATA_WIDTH + 7) / 8) * 8;

    localparam int SUM_W  = DATA_WIDTH + 2;
    localparam int RES_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + COEF_BITS;
    localparam int X_W    = SUM_W + 1;
    localparam int THIRD_K = X_W + 1;

    typedef logic [NUM_ELEMS-1:0][DATA_WIDTH-1:0] vec_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [SUM_W-1:0]         mag_t;
    typedef logic signed [RES_W-1:0]  res_t;
    typedef logic [COEF_BITS-1:0]     coef_t;

    typedef enum logic
    {
        DIR_DECOMPOSE   = 1'b0,
        DIR_RECONSTRUCT = 1'b1
    } dir_t;

    // Coefficients with COEF_BITS fraction bits, rounded to nearest
    localparam coef_t K_ISQ2 = coef_t'(759250125);
    localparam coef_t K_ISQ6 = coef_t'(438353264);
    localparam coef_t K_SQ23 = coef_t'(876706528);

    localparam longint unsigned THIRD_M_L = (64'd1 << THIRD_K) / 64'd3;
    localparam logic [X_W-1:0]  THIRD_M   = X_W'(THIRD_M_L);

    localparam res_t RES_MAX = res_t'((longint'(1) << (DATA_WIDTH - 1)) - longint'(1));
    localparam res_t RES_MIN = res_t'(-(longint'(1) << (DATA_WIDTH - 1)));

    function automatic sum_t sx(input logic [DATA_WIDTH-1:0] v);
        return sum_t'($signed(v));
    endfunction

    function automatic mag_t magn(input sum_t a);
        return (a < 0) ? mag_t'(-a) : mag_t'(a);
    endfunction

    function automatic res_t apply_sign(input logic neg, input mag_t q);
        res_t r;
        r = res_t'({1'b0, q});
        return neg ? -r : r;
    endfunction

    // round(a * c / 2^COEF_BITS), ties away from zero
    function automatic res_t mulc(input sum_t a, input coef_t c);
        mag_t              m;
        logic [PROD_W-1:0] p;
        mag_t              q;
        m = magn(a);
        p = PROD_W'(m) * PROD_W'(c);
        p = p + (PROD_W'(1) << (COEF_BITS - 1));
        q = p[PROD_W-1:COEF_BITS];
        return apply_sign(a < 0, q);
    endfunction

    // round(a / 2), ties away from zero
    function automatic res_t half(input sum_t a);
        logic [X_W-1:0] x;
        mag_t           q;
        x = {1'b0, magn(a)} + X_W'(1);
        q = x[X_W-1:1];
        return apply_sign(a < 0, q);
    endfunction

    // round(a / 3), ties away from zero: floor((|a| + 1) / 3) by reciprocal and one correction
    function automatic res_t third(input sum_t a);
        logic [X_W-1:0]     x;
        logic [2*X_W-1:0]   p;
        mag_t               q;
        logic [X_W+1:0]     rem;
        x   = {1'b0, magn(a)} + X_W'(1);
        p   = (2 * X_W)'(x) * (2 * X_W)'(THIRD_M);
        q   = mag_t'(p >> THIRD_K);
        rem = (X_W + 2)'(x) - (X_W + 2)'(q) * (X_W + 2)'(3);
        if (rem >= (X_W + 2)'(3))
        begin
            q = q + mag_t'(1);
        end
        return apply_sign(a < 0, q);
    endfunction

    function automatic logic over_range(input res_t r);
        return (r > RES_MAX) || (r < RES_MIN);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] clamp(input res_t r);
        logic [DATA_WIDTH-1:0] v;
        if (r > RES_MAX)
        begin
            v = RES_MAX[DATA_WIDTH-1:0];
        end
        else if (r < RES_MIN)
        begin
            v = RES_MIN[DATA_WIDTH-1:0];
        end
        else
        begin
            v = r[DATA_WIDTH-1:0];
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/stt_datapath.sv =====
// Combinational decomposition and reconstruction of one rank-two tensor item.
`timescale 1ns / 1ps

module stt_datapath
(
    input  stt_pkg::dir_t direction,
    input  stt_pkg::vec_t in_vec,
    output stt_pkg::vec_t res_vec,
    output logic          saturated
);

    stt_pkg::sum_t a [stt_pkg::NUM_ELEMS];
    stt_pkg::sum_t op0;
    stt_pkg::sum_t op1;
    stt_pkg::sum_t op2;
    stt_pkg::sum_t op3;
    stt_pkg::sum_t op4;
    stt_pkg::res_t m0;
    stt_pkg::res_t m1;
    stt_pkg::res_t m2;
    stt_pkg::res_t m3;
    stt_pkg::res_t m4;
    stt_pkg::res_t m5;
    stt_pkg::res_t t0;
    stt_pkg::res_t vx;
    stt_pkg::res_t vy;
    stt_pkg::res_t vz;
    stt_pkg::res_t r [stt_pkg::NUM_ELEMS];

    always_comb
    begin
        for (int i = 0; i < stt_pkg::NUM_ELEMS; i++)
        begin
            a[i] = stt_pkg::sx(in_vec[i]);
        end
    end

    // Share the K_ISQ2 and K_ISQ6 coefficient products between both directions
    assign op0 = (direction == stt_pkg::DIR_RECONSTRUCT) ? a[4] : a[1] + a[3];
    assign op1 = (direction == stt_pkg::DIR_RECONSTRUCT) ? a[5] : a[5] + a[7];
    assign op2 = (direction == stt_pkg::DIR_RECONSTRUCT) ? a[6] : a[8] + a[8] - a[0] - a[4];
    assign op3 = (direction == stt_pkg::DIR_RECONSTRUCT) ? a[7] : a[2] + a[6];
    assign op4 = (direction == stt_pkg::DIR_RECONSTRUCT) ? a[8] : a[0] - a[4];

    assign m0 = stt_pkg::mulc(op0, stt_pkg::K_ISQ2);
    assign m1 = stt_pkg::mulc(op1, stt_pkg::K_ISQ2);
    assign m2 = stt_pkg::mulc(op2, stt_pkg::K_ISQ6);
    assign m3 = stt_pkg::mulc(op3, stt_pkg::K_ISQ2);
    assign m4 = stt_pkg::mulc(op4, stt_pkg::K_ISQ2);
    assign m5 = stt_pkg::mulc(a[6], stt_pkg::K_SQ23);

    assign t0 = stt_pkg::res_t'(a[0]);
    assign vx = stt_pkg::res_t'(a[1]);
    assign vy = stt_pkg::res_t'(a[2]);
    assign vz = stt_pkg::res_t'(a[3]);

    always_comb
    begin
        if (direction == stt_pkg::DIR_RECONSTRUCT)
        begin
            r[0] = t0 + m4 - m2;
            r[1] = m0 + vz;
            r[2] = m3 - vy;
            r[3] = m0 - vz;
            r[4] = t0 - m4 - m2;
            r[5] = m1 + vx;
            r[6] = m3 + vy;
            r[7] = m1 - vx;
            r[8] = t0 + m5;
        end
        else
        begin
            r[0] = stt_pkg::third(a[0] + a[4] + a[8]);
            r[1] = stt_pkg::half(a[5] - a[7]);
            r[2] = stt_pkg::half(a[6] - a[2]);
            r[3] = stt_pkg::half(a[1] - a[3]);
            r[4] = m0;
            r[5] = m1;
            r[6] = m2;
            r[7] = m3;
            r[8] = m4;
        end
    end

    always_comb
    begin
        saturated = 1'b0;
        for (int i = 0; i < stt_pkg::NUM_ELEMS; i++)
        begin
            res_vec[i] = stt_pkg::clamp(r[i]);
            saturated  = saturated | stt_pkg::over_range(r[i]);
        end
    end

endmodule

// ===== hw/rtl/spherical_tensor_transform_unit.sv =====
// Top level of the spherical tensor transform unit: stream handshake, registers and config.
`timescale 1ns / 1ps

// Takes one tensor item per transaction and returns one result item: the item is captured
// in an input register, transformed by one pass of fixed-coefficient logic, and held in a
// result register until the output side takes it. A new item is accepted every cycle while
// the output side is not stalling, so sustained throughput is one item per clock. cfg_data
// selects the direction (0 decompose, 1 reconstruct); write it only while no items are in
// flight.
module spherical_tensor_transform_unit
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data,           // direction

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [stt_pkg::TDATA_W-1:0] s_axis_tdata,       // in_0 .. in_8

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [stt_pkg::TDATA_W-1:0] m_axis_tdata,       // out_0 .. out_8
    output logic [0:0]                  m_axis_tuser        // saturated
);

    localparam int VEC_W = stt_pkg::NUM_ELEMS * stt_pkg::DATA_WIDTH;

    stt_pkg::dir_t direction_reg;
    stt_pkg::dir_t direction_next;
    logic          in_valid_reg;
    logic          in_valid_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    stt_pkg::vec_t in_data_reg;
    stt_pkg::vec_t out_data_reg;
    logic          out_sat_reg;
    stt_pkg::vec_t res_vec;
    logic          res_sat;
    logic          advance;
    logic          in_fire;
    logic          move;
    logic          out_fire;
    logic          out_extreme;

    stt_datapath u_datapath
    (
        .direction (direction_reg),
        .in_vec    (in_data_reg),
        .res_vec   (res_vec),
        .saturated (res_sat)
    );

    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign move          = in_valid_reg && advance;
    assign out_fire      = out_valid_reg && m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = stt_pkg::TDATA_W'(out_data_reg);
    assign m_axis_tuser  = out_sat_reg;

    always_comb
    begin
        direction_next = direction_reg;
        if (cfg_valid && cfg_ready)
        begin
            direction_next = stt_pkg::dir_t'(cfg_data);
        end
        in_valid_next  = in_fire || (in_valid_reg && !advance);
        out_valid_next = move || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= stt_pkg::DIR_DECOMPOSE;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            direction_reg <= direction_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_data_reg <= s_axis_tdata[VEC_W-1:0];
        end
        if (move)
        begin
            out_data_reg <= res_vec;
            out_sat_reg  <= res_sat;
        end
    end

    always_comb
    begin
        out_extreme = 1'b0;
        for (int i = 0; i < stt_pkg::NUM_ELEMS; i++)
        begin
            out_extreme = out_extreme
                | (out_data_reg[i] == stt_pkg::RES_MAX[stt_pkg::DATA_WIDTH-1:0])
                | (out_data_reg[i] == stt_pkg::RES_MIN[stt_pkg::DATA_WIDTH-1:0]);
        end
    end

    a_sat_means_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sat_reg) |-> out_extreme)
        else $error("saturation flag set with no clamped element");

    a_occupancy_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !out_fire) |=>
        ($countones({in_valid_reg, out_valid_reg}) ==
         $past($countones({in_valid_reg, out_valid_reg})) + 1))
        else $error("accepted transaction lost in the pipeline");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are full and stalled");

    a_direction_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_valid |=> $stable(direction_reg))
        else $error("direction changed without a config transaction");

endmodule

// ===== tb/spherical_tensor_transform_unit_tb.sv =====
// Self-checking stream testbench for the spherical tensor transform unit in both directions.
`timescale 1ns / 1ps

module spherical_tensor_transform_unit_tb;

    import stt_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed
    {
        vec_t data;
        logic sat;
    } result_t;

    localparam int   COEF_FRAC    = 30;
    localparam u64_t C_INV_SQRT2  = 64'd759250125;
    localparam u64_t C_INV_SQRT6  = 64'd438353264;
    localparam u64_t C_SQRT_2_3   = 64'd876706528;
    localparam u64_t COEF_HALF    = 64'd1 << (COEF_FRAC - 1);
    localparam longint ELEM_MAX   = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    localparam longint ELEM_MIN   = -(longint'(1) << (DATA_WIDTH - 1));
    localparam int   VMAX         = 32'h7FFF_FFFF;
    localparam int   VMIN         = 32'h8000_0000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    dir_t                 direction = DIR_DECOMPOSE;
    vec_t                 pending_tensors [$];
    result_t              expected_results [$];
    result_t              want;
    int                   send_gap = 0;
    int                   send_burst = 0;
    int                   stall_left = 0;
    int                   stall_burst = 0;
    int                   mismatches = 0;
    int                   tensors_sent = 0;
    int                   results_checked = 0;
    int                   saturated_seen = 0;
    int                   settings_used = 1;
    int                   k;

    spherical_tensor_transform_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic longint round_div(input longint n, input longint d);
        longint m;
        longint q;
        m = (n < 0) ? -n : n;
        q = (2 * m + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint scale_coef(input longint a, input u64_t c);
        u64_t m;
        u64_t q;
        m = (a < 0) ? -a : a;
        q = (m * c + COEF_HALF) >> COEF_FRAC;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic result_t transform_tensor(input vec_t t, input dir_t dir);
        longint  a [NUM_ELEMS];
        longint  r [NUM_ELEMS];
        longint  sxy;
        longint  syz;
        longint  sxz;
        longint  hz;
        longint  szz;
        longint  hd;
        result_t res;
        int      i;
        res.sat = 1'b0;
        for (i = 0; i < NUM_ELEMS; i++)
            a[i] = longint'($signed(t[i]));
        if (dir == DIR_DECOMPOSE)
        begin
            r[0] = round_div(a[0] + a[4] + a[8], 3);
            r[1] = round_div(a[5] - a[7], 2);
            r[2] = round_div(a[6] - a[2], 2);
            r[3] = round_div(a[1] - a[3], 2);
            r[4] = scale_coef(a[1] + a[3], C_INV_SQRT2);
            r[5] = scale_coef(a[5] + a[7], C_INV_SQRT2);
            r[6] = scale_coef(2 * a[8] - a[0] - a[4], C_INV_SQRT6);
            r[7] = scale_coef(a[2] + a[6], C_INV_SQRT2);
            r[8] = scale_coef(a[0] - a[4], C_INV_SQRT2);
        end
        else
        begin
            sxy  = scale_coef(a[4], C_INV_SQRT2);
            syz  = scale_coef(a[5], C_INV_SQRT2);
            hz   = scale_coef(a[6], C_INV_SQRT6);
            szz  = scale_coef(a[6], C_SQRT_2_3);
            sxz  = scale_coef(a[7], C_INV_SQRT2);
            hd   = scale_coef(a[8], C_INV_SQRT2);
            r[0] = a[0] + hd - hz;
            r[1] = sxy + a[3];
            r[2] = sxz - a[2];
            r[3] = sxy - a[3];
            r[4] = a[0] - hd - hz;
            r[5] = syz + a[1];
            r[6] = sxz + a[2];
            r[7] = syz - a[1];
            r[8] = a[0] + szz;
        end
        for (i = 0; i < NUM_ELEMS; i++)
        begin
            if (r[i] > ELEM_MAX)
            begin
                r[i] = ELEM_MAX;
                res.sat = 1'b1;
            end
            else if (r[i] < ELEM_MIN)
            begin
                r[i] = ELEM_MIN;
                res.sat = 1'b1;
            end
            res.data[i] = DATA_WIDTH'(r[i]);
        end
        return res;
    endfunction

    // Mostly short gaps, some long ones, and occasional runs with no gap at all
    function automatic int pick_idle(inout int burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if (roll < 3)
        begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int rand_elem();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: return int'($urandom);
            3:
            begin
                case ($urandom_range(0, 6))
                    0: return VMAX;
                    1: return VMIN;
                    2: return VMAX - 1;
                    3: return VMIN + 1;
                    4: return -1;
                    5: return 1;
                    default: return 0;
                endcase
            end
            4, 5, 6: return int'($urandom_range(0, 13107200)) - 6553600;
            7, 8: return int'($urandom_range(0, 20)) - 10;
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                    return 32'h4000_0000 + int'($urandom_range(0, 32'h3FFF_FFFF));
                return -32'sh4000_0000 - int'($urandom_range(0, 32'h3FFF_FFFF));
            end
        endcase
    endfunction

    task automatic queue_tensor(input int e0, input int e1, input int e2,
                                input int e3, input int e4, input int e5,
                                input int e6, input int e7, input int e8);
        pending_tensors.push_back({e8, e7, e6, e5, e4, e3, e2, e1, e0});
    endtask

    task automatic queue_random(input int count);
        int n;
        for (n = 0; n < count; n++)
            queue_tensor(rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                         rand_elem(), rand_elem(), rand_elem(), rand_elem());
    endtask

    // Hold until every queued tensor went out and every result came back
    task automatic wait_idle();
        @(negedge clk);
        while (pending_tensors.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_direction(input dir_t dir);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= dir;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        direction = dir;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic log_mismatch(input string what, input longint expv, input longint actv);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch on %s at %0t ns: expected %0d, got %0d", what, $time, expv, actv);
    endtask

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_results.push_back(transform_tensor(s_axis_tdata, direction));
            tensors_sent++;
        end
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_tensors.size() > 0)
            begin
                s_axis_tdata  <= pending_tensors.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap = pick_idle(send_burst);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (m_axis_tuser[0] === 1'b1)
                saturated_seen++;
            if (expected_results.size() == 0)
            begin
                log_mismatch("result with nothing expected", 0, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                for (k = 0; k < NUM_ELEMS; k++)
                begin
                    if (m_axis_tdata[k*DATA_WIDTH +: DATA_WIDTH] !== want.data[k])
                        log_mismatch($sformatf("out_%0d", k), $signed(want.data[k]),
                                     $signed(m_axis_tdata[k*DATA_WIDTH +: DATA_WIDTH]));
                end
                if (m_axis_tuser[0] !== want.sat)
                    log_mismatch("saturated", want.sat, m_axis_tuser[0]);
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left = pick_idle(stall_burst);
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // decompose, the reset setting
        queue_tensor(0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_tensor(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX);
        queue_tensor(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN);
        queue_tensor(65536, 0, 0, 0, 65536, 0, 0, 0, 65536);
        queue_tensor(1, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_tensor(2, -1, 0, 0, 0, 1, -1, 0, 0);
        queue_tensor(-2, 1, 0, 0, 0, -1, 1, 0, 0);
        queue_tensor(0, VMAX, VMAX, VMIN, 0, VMAX, VMIN, VMIN, 0);
        queue_tensor(VMAX, VMIN, 0, VMIN, VMIN, 0, 0, 0, VMAX);
        queue_tensor(VMIN, 0, 0, 0, VMIN, 0, 0, 0, VMAX);
        queue_tensor(98304, -16384, 196608, 131072, -491520, 8192, -196608, 262144, 655360);
        queue_tensor(-1, -1, -1, -1, -1, -1, -1, -1, -1);
        queue_random(160);
        wait_idle();

        write_direction(DIR_RECONSTRUCT);
        queue_tensor(0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_tensor(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX);
        queue_tensor(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN);
        queue_tensor(65536, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_tensor(VMIN, 0, 0, 0, 0, 0, VMIN, 0, 0);
        queue_tensor(0, 1, -1, 1, 1, -1, 1, -1, 1);
        queue_tensor(0, 0, 0, 0, 3, -3, 3, 3, -3);
        queue_tensor(0, VMAX, VMIN, VMAX, VMAX, VMAX, 0, VMIN, 0);
        queue_tensor(131072, -32768, 49152, 16384, 92682, -46341, 160529, 23170, -115852);
        queue_tensor(VMAX, 0, 0, 0, 0, 0, 0, 0, VMIN);
        queue_random(160);
        wait_idle();

        write_direction(DIR_DECOMPOSE);
        queue_random(150);
        wait_idle();

        write_direction(DIR_RECONSTRUCT);
        queue_random(150);
        wait_idle();

        write_direction(DIR_DECOMPOSE);
        queue_random(40);
        wait_idle();

        $display("Run covered %0d tensors in both directions over %0d register settings;",
                 tensors_sent, settings_used);
        $display("%0d results checked, %0d of them saturated, %0d mismatches.",
                 results_checked, saturated_seen, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
